// ===== src/acc_pkg.sv =====
// ----------------------------------------------------------------------------
// Alarm clock controller package
// Shared item types and constants of the 12-hour alarm clock controller.
// ----------------------------------------------------------------------------
package acc_pkg;

    localparam logic [5:0] LAST_MINUTE      = 6'd59;
    localparam logic [3:0] HOURS_PER_HALF   = 4'd12;
    localparam logic [7:0] RING_TICKS_RESET = 8'd60;

    localparam logic [1:0] CURSOR_HOUR   = 2'd0;
    localparam logic [1:0] CURSOR_MINUTE = 2'd1;
    localparam logic [1:0] CURSOR_PM     = 2'd2;

    typedef struct packed {
        logic [5:0] time_minute;
        logic [3:0] time_hour;
        logic       time_pm;
        logic       press_mode;
        logic       press_left;
        logic       press_right;
        logic       press_up;
        logic       press_down;
        logic       press_confirm;
    } tick_t;

    typedef struct packed {
        logic       buzzer_on;
        logic       editing;
        logic [1:0] cursor;
        logic [3:0] edit_hour;
        logic [5:0] edit_minute;
        logic       edit_pm;
        logic       armed;
    } result_t;

endpackage

// ===== src/acc_tick_if.sv =====
// ----------------------------------------------------------------------------
// Tick channel
// Carries one tick beat: the current time and the button presses.
// ----------------------------------------------------------------------------
interface acc_tick_if;
    logic       valid;
    logic       ready;
    logic [5:0] time_minute;
    logic [3:0] time_hour;
    logic       time_pm;
    logic       press_mode;
    logic       press_left;
    logic       press_right;
    logic       press_up;
    logic       press_down;
    logic       press_confirm;

    modport source (
        output valid, time_minute, time_hour, time_pm, press_mode, press_left,
               press_right, press_up, press_down, press_confirm,
        input  ready
    );
    modport sink (
        input  valid, time_minute, time_hour, time_pm, press_mode, press_left,
               press_right, press_up, press_down, press_confirm,
        output ready
    );
endinterface

// ===== src/acc_result_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Carries one result beat: buzzer drive and the alarm edit view.
// ----------------------------------------------------------------------------
interface acc_result_if;
    logic       valid;
    logic       ready;
    logic       buzzer_on;
    logic       editing;
    logic [1:0] cursor;
    logic [3:0] edit_hour;
    logic [5:0] edit_minute;
    logic       edit_pm;
    logic       armed;

    modport source (
        output valid, buzzer_on, editing, cursor, edit_hour, edit_minute, edit_pm,
               armed,
        input  ready
    );
    modport sink (
        input  valid, buzzer_on, editing, cursor, edit_hour, edit_minute, edit_pm,
               armed,
        output ready
    );
endinterface

// ===== src/acc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration channel
// Carries one write beat of the ring limit register.
// ----------------------------------------------------------------------------
interface acc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] ring_ticks;

    modport source (output valid, ring_ticks, input ready);
    modport sink (input valid, ring_ticks, output ready);
endinterface

// ===== src/alarm_clock_controller_top.sv =====
// ----------------------------------------------------------------------------
// Alarm clock controller, 12-hour form
// A tick is registered in the input stage and its result in the output stage.
// Throughput is one tick per cycle in a single core step while output is free.
// The input and output registers let a new tick enter while a result waits.
// Reset clears all alarm state and sets the ring limit to 60 ticks.
// ----------------------------------------------------------------------------
module alarm_clock_controller_top
    import acc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    acc_tick_if.sink      tick,
    acc_result_if.source  result,
    acc_cfg_if.sink       cfg
);

    logic [7:0] ring_limit_reg;
    logic [7:0] ring_limit_next;
    logic       in_valid;
    logic       out_free;
    logic       advance;
    tick_t      item;
    result_t    res;

    assign cfg.ready       = 1'b1;
    assign ring_limit_next = (cfg.valid && cfg.ready) ? cfg.ring_ticks : ring_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_limit_reg <= RING_TICKS_RESET;
        end
        else
        begin
            ring_limit_reg <= ring_limit_next;
        end
    end

    assign advance = in_valid && out_free;

    acc_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick),
        .advance (advance),
        .valid   (in_valid),
        .item    (item)
    );

    acc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item       (item),
        .ring_ticks (ring_limit_reg),
        .res        (res)
    );

    acc_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .res    (res),
        .result (result),
        .free   (out_free)
    );

endmodule

// ===== src/acc_in_stage.sv =====
// ----------------------------------------------------------------------------
// Input stage
// Registers an accepted tick beat until the core consumes it.
// ----------------------------------------------------------------------------
module acc_in_stage
    import acc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    acc_tick_if.sink  tick,
    input  logic      advance,
    output logic      valid,
    output tick_t     item
);

    logic  valid_reg;
    logic  valid_next;
    tick_t item_reg;
    logic  take;

    assign tick.ready = !valid_reg || advance;
    assign take       = tick.valid && tick.ready;
    assign valid_next = take || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= '{time_minute:   tick.time_minute,
                          time_hour:     tick.time_hour,
                          time_pm:       tick.time_pm,
                          press_mode:    tick.press_mode,
                          press_left:    tick.press_left,
                          press_right:   tick.press_right,
                          press_up:      tick.press_up,
                          press_down:    tick.press_down,
                          press_confirm: tick.press_confirm};
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

// ===== src/acc_core.sv =====
// ----------------------------------------------------------------------------
// Controller core
// Holds the edit, alarm and ring state and applies one tick per advance.
// ----------------------------------------------------------------------------
module acc_core
    import acc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  tick_t      item,
    input  logic [7:0] ring_ticks,
    output result_t    res
);

    logic       edit_mode_reg,    edit_mode_next;
    logic [1:0] cursor_pos_reg,   cursor_pos_next;
    logic [3:0] work_hour_reg,    work_hour_next;
    logic [5:0] work_minute_reg,  work_minute_next;
    logic       work_pm_reg,      work_pm_next;
    logic       alarm_armed_reg,  alarm_armed_next;
    logic [3:0] saved_hour_reg,   saved_hour_next;
    logic [5:0] saved_minute_reg, saved_minute_next;
    logic       saved_pm_reg,     saved_pm_next;
    logic       ringing_reg,      ringing_next;
    logic [7:0] ring_count_reg,   ring_count_next;

    always_comb
    begin
        logic [3:0] hour;
        logic [3:0] now_hour;
        logic [7:0] count_inc;

        edit_mode_next    = edit_mode_reg ^ item.press_mode;
        cursor_pos_next   = cursor_pos_reg;
        hour              = work_hour_reg;
        work_minute_next  = work_minute_reg;
        work_pm_next      = work_pm_reg;
        alarm_armed_next  = alarm_armed_reg;
        saved_hour_next   = saved_hour_reg;
        saved_minute_next = saved_minute_reg;
        saved_pm_next     = saved_pm_reg;
        ringing_next      = ringing_reg;
        ring_count_next   = ring_count_reg;

        if (edit_mode_next)
        begin
            if (item.press_left && cursor_pos_next != CURSOR_HOUR)
            begin
                cursor_pos_next = cursor_pos_next - 2'd1;
            end
            if (item.press_right && cursor_pos_next < CURSOR_PM)
            begin
                cursor_pos_next = cursor_pos_next + 2'd1;
            end
            if (item.press_up)
            begin
                case (cursor_pos_next)
                    CURSOR_HOUR:
                    begin
                        if (hour >= HOURS_PER_HALF)
                        begin
                            hour = 4'd1;
                        end
                        else
                        begin
                            hour = hour + 4'd1;
                        end
                    end
                    CURSOR_MINUTE:
                    begin
                        work_minute_next = (work_minute_next >= LAST_MINUTE) ? 6'd0
                                                                             : work_minute_next + 6'd1;
                    end
                    default:
                    begin
                        work_pm_next = ~work_pm_next;
                    end
                endcase
            end
            if (item.press_down)
            begin
                case (cursor_pos_next)
                    CURSOR_HOUR:
                    begin
                        hour = (hour > 4'd1) ? hour - 4'd1 : HOURS_PER_HALF;
                    end
                    CURSOR_MINUTE:
                    begin
                        work_minute_next = (work_minute_next != 6'd0) ? work_minute_next - 6'd1
                                                                      : LAST_MINUTE;
                    end
                    default:
                    begin
                        work_pm_next = ~work_pm_next;
                    end
                endcase
            end
        end
        work_hour_next = hour;

        if (item.press_confirm)
        begin
            if (edit_mode_next)
            begin
                edit_mode_next    = 1'b0;
                alarm_armed_next  = 1'b1;
                saved_hour_next   = work_hour_next;
                saved_minute_next = work_minute_next;
                saved_pm_next     = work_pm_next;
            end
            else if (ringing_next)
            begin
                ringing_next    = 1'b0;
                ring_count_next = 8'd0;
            end
        end

        if (item.time_hour == 4'd0)
        begin
            now_hour = HOURS_PER_HALF;
        end
        else if (item.time_hour > HOURS_PER_HALF)
        begin
            now_hour = item.time_hour - HOURS_PER_HALF;
        end
        else
        begin
            now_hour = item.time_hour;
        end

        if (alarm_armed_next)
        begin
            ringing_next = (item.time_minute == saved_minute_next)
                        && (now_hour == saved_hour_next)
                        && (item.time_pm == saved_pm_next);
        end

        count_inc = ring_count_next + 8'd1;
        if (ringing_next)
        begin
            ring_count_next = count_inc;
            if (count_inc >= ring_ticks)
            begin
                ringing_next    = 1'b0;
                ring_count_next = 8'd0;
            end
        end
        else
        begin
            ring_count_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edit_mode_reg    <= 1'b0;
            cursor_pos_reg   <= CURSOR_HOUR;
            work_hour_reg    <= 4'd0;
            work_minute_reg  <= 6'd0;
            work_pm_reg      <= 1'b0;
            alarm_armed_reg  <= 1'b0;
            saved_hour_reg   <= 4'd0;
            saved_minute_reg <= 6'd0;
            saved_pm_reg     <= 1'b0;
            ringing_reg      <= 1'b0;
            ring_count_reg   <= 8'd0;
        end
        else if (advance)
        begin
            edit_mode_reg    <= edit_mode_next;
            cursor_pos_reg   <= cursor_pos_next;
            work_hour_reg    <= work_hour_next;
            work_minute_reg  <= work_minute_next;
            work_pm_reg      <= work_pm_next;
            alarm_armed_reg  <= alarm_armed_next;
            saved_hour_reg   <= saved_hour_next;
            saved_minute_reg <= saved_minute_next;
            saved_pm_reg     <= saved_pm_next;
            ringing_reg      <= ringing_next;
            ring_count_reg   <= ring_count_next;
        end
    end

    assign res = '{buzzer_on:   ringing_next,
                   editing:     edit_mode_next,
                   cursor:      cursor_pos_next,
                   edit_hour:   work_hour_next,
                   edit_minute: work_minute_next,
                   edit_pm:     work_pm_next,
                   armed:       alarm_armed_next};

endmodule

// ===== src/acc_out_stage.sv =====
// ----------------------------------------------------------------------------
// Output stage
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module acc_out_stage
    import acc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  result_t       res,
    acc_result_if.source  result,
    output logic          free
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free       = !valid_reg || result.ready;
    assign valid_next = load || (valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign result.valid       = valid_reg;
    assign result.buzzer_on   = res_reg.buzzer_on;
    assign result.editing     = res_reg.editing;
    assign result.cursor      = res_reg.cursor;
    assign result.edit_hour   = res_reg.edit_hour;
    assign result.edit_minute = res_reg.edit_minute;
    assign result.edit_pm     = res_reg.edit_pm;
    assign result.armed       = res_reg.armed;

endmodule
